FILE: rtl/core/sdss_pkg.sv
// Shared types, codes and constants of the syringe dose step sequencer.
package sdss_pkg;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_DOSE  = 3'd1;
   localparam logic [2:0] CMD_FILL  = 3'd2;
   localparam logic [2:0] CMD_EMPTY = 3'd3;
   localparam logic [2:0] CMD_STOP  = 3'd4;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_DOSE  = 2'd1;
   localparam logic [1:0] MODE_FILL  = 2'd2;
   localparam logic [1:0] MODE_EMPTY = 2'd3;

   localparam logic [7:0] DOSE_MAX        = 8'd250;
   localparam logic [7:0] QUANTITY_RESET  = 8'd1;
   localparam logic [7:0] STEPS_RESET     = 8'd13;

   localparam logic CSR_DOSE_QUANTITY  = 1'b0;
   localparam logic CSR_STEPS_PER_UNIT = 1'b1;

   typedef struct packed {
      logic [2:0] cmd;
      logic       full_reached;
      logic       empty_reached;
   } req_type;

   typedef struct packed {
      logic       step_pulse;
      logic       motor_enable;
      logic       direction;
      logic [1:0] run_mode;
      logic       dose_done;
      logic       empty_alarm;
   } rsp_type;

   typedef struct packed {
      logic [7:0] dose_quantity;
      logic [7:0] steps_per_unit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] units_left;
      logic [7:0] pulses_left;
      logic       enable;
      logic       dir;
      logic       empty_seen;
   } seq_state_type;

endpackage

FILE: rtl/core/sdss_step.sv
// Next-state and result logic for one tick of the dose step sequencer.
module sdss_step import sdss_pkg::*; (
   input  seq_state_type cur,
   input  req_type       req,
   input  cfg_type       cfg,
   output seq_state_type nxt,
   output rsp_type       rsp
);

   logic [7:0] eff_units;
   logic [7:0] eff_steps;
   logic [7:0] units_dec;
   logic       do_dose;
   logic       pulse;
   logic       done;
   logic       alarm;
   logic       limit;

   always_comb begin
      if (cfg.dose_quantity == 8'd0) begin
         eff_units = 8'd1;
      end else if (cfg.dose_quantity > DOSE_MAX) begin
         eff_units = DOSE_MAX;
      end else begin
         eff_units = cfg.dose_quantity;
      end
      eff_steps = (cfg.steps_per_unit == 8'd0) ? 8'd1 : cfg.steps_per_unit;
   end

   always_comb begin
      nxt       = cur;
      do_dose   = 1'b0;
      pulse     = 1'b0;
      done      = 1'b0;
      alarm     = 1'b0;
      units_dec = 8'd0;
      limit     = (cur.mode == MODE_FILL) ? req.full_reached : req.empty_reached;

      unique case (cur.mode)
         MODE_IDLE: begin
            unique case (req.cmd)
               CMD_DOSE: begin
                  if (req.empty_reached) begin
                     alarm = 1'b1;
                  end else begin
                     nxt.mode        = MODE_DOSE;
                     nxt.units_left  = eff_units;
                     nxt.pulses_left = eff_steps;
                     nxt.dir         = 1'b0;
                     nxt.enable      = 1'b1;
                     nxt.empty_seen  = 1'b0;
                     do_dose         = 1'b1;
                  end
               end
               CMD_FILL: begin
                  nxt.dir = 1'b1;
                  if (!req.full_reached) begin
                     nxt.mode   = MODE_FILL;
                     nxt.enable = 1'b1;
                     pulse      = 1'b1;
                  end else begin
                     nxt.enable = 1'b0;
                  end
               end
               CMD_EMPTY: begin
                  nxt.dir = 1'b0;
                  if (!req.empty_reached) begin
                     nxt.mode   = MODE_EMPTY;
                     nxt.enable = 1'b1;
                     pulse      = 1'b1;
                  end else begin
                     nxt.enable = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         MODE_DOSE: begin
            do_dose = 1'b1;
         end
         MODE_FILL, MODE_EMPTY: begin
            if (req.cmd == CMD_STOP || limit) begin
               nxt.mode   = MODE_IDLE;
               nxt.enable = 1'b0;
            end else begin
               pulse = 1'b1;
            end
         end
      endcase

      // A dose item always pulses; the empty switch cuts the enable and sets empty_seen but does not stop the dose.
      if (do_dose) begin
         if (req.empty_reached) begin
            nxt.enable     = 1'b0;
            nxt.empty_seen = 1'b1;
         end
         pulse = 1'b1;
         if (nxt.pulses_left > 8'd1) begin
            nxt.pulses_left = nxt.pulses_left - 8'd1;
         end else begin
            units_dec       = (nxt.units_left != 8'd0) ? nxt.units_left - 8'd1 : 8'd0;
            nxt.pulses_left = eff_steps;
            nxt.units_left  = units_dec;
            if (units_dec == 8'd0) begin
               nxt.pulses_left = 8'd0;
               nxt.mode        = MODE_IDLE;
               nxt.enable      = 1'b0;
               done            = 1'b1;
               alarm           = nxt.empty_seen;
               nxt.empty_seen  = 1'b0;
            end
         end
      end

      rsp.step_pulse   = pulse;
      rsp.motor_enable = nxt.enable;
      rsp.direction    = nxt.dir;
      rsp.run_mode     = nxt.mode;
      rsp.dose_done    = done;
      rsp.empty_alarm  = alarm;
   end

endmodule

FILE: rtl/core/syringe_dose_step_sequencer.sv
// Top level of the syringe dose step sequencer: handshake stages, registers and state.
//
// Each accepted item is one step-pulse period and yields exactly one result item.
// An item is held in the input register, and the next-state logic runs on it there
// and writes the sequencer state and the result register together; the block
// takes one item per clock when rsp_stall is low; the result register and input
// register together let a new item in while a finished result waits. dose_quantity
// (byte address 0) and steps_per_unit (byte address 4) are read by the step logic
// and should only be written while idle.
module syringe_dose_step_sequencer import sdss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic          in_valid_ff;
   req_type       in_data_ff;
   logic          out_valid_ff;
   rsp_type       out_data_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_type       rsp_in;
   cfg_type       cfg_ff;
   logic          out_free;
   logic          advance;
   logic          csr_write;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (csr_paddr[2] == CSR_STEPS_PER_UNIT) begin
         csr_prdata = {24'd0, cfg_ff.steps_per_unit};
      end else begin
         csr_prdata = {24'd0, cfg_ff.dose_quantity};
      end
   end

   sdss_step u_step (
      .cur (state_ff),
      .req (in_data_ff),
      .cfg (cfg_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dose_quantity  <= QUANTITY_RESET;
         cfg_ff.steps_per_unit <= STEPS_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_DOSE_QUANTITY) begin
            cfg_ff.dose_quantity <= csr_pwdata[7:0];
         end else begin
            cfg_ff.steps_per_unit <= csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   // While dosing both counters hold at least one; reaching zero ends the dose.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_DOSE |-> state_ff.pulses_left != 8'd0 && state_ff.units_left != 8'd0)
      else $error("dose counters reached zero while dosing");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == MODE_IDLE |-> !state_ff.enable)
      else $error("motor enabled while idle");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_data_ff.dose_done || out_data_ff.empty_alarm)
         |-> out_data_ff.run_mode == MODE_IDLE)
      else $error("dose done or alarm reported outside idle");

   assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.mode == MODE_DOSE |-> rsp_in.step_pulse)
      else $error("dosing item without a step pulse");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> out_valid_ff && rsp_stall)
      else $error("input stalled while result register can load");

endmodule
